// File: sv/sipq_pkg.sv
// ----------------------------------------------------------------------------
// sipq_pkg: shared types and constants of the sorted insert priority queue
// Word layouts of both channels, the cell control group and size defaults.
// ----------------------------------------------------------------------------
package sipq_pkg;

    localparam int SIPQ_DEPTH    = 16;
    localparam int KEY_W         = 32;
    localparam int TAG_W         = 32;
    localparam int POS_W         = 8;
    localparam int ENTRY_COUNT_W = 9;

    typedef enum logic {
        OP_INSERT = 1'b0,
        OP_READ   = 1'b1
    } t_op;

    typedef struct packed {
        t_op                      op;
        logic signed [KEY_W-1:0]  key;
        logic        [TAG_W-1:0]  tag;
        logic        [POS_W-1:0]  position;
    } t_in_word;

    typedef struct packed {
        logic signed [KEY_W-1:0]          out_key;
        logic        [TAG_W-1:0]          out_tag;
        logic                             read_valid;
        logic                             overflow;
        logic        [ENTRY_COUNT_W-1:0]  entry_count;
    } t_out_word;

    // per-cell control from the slot decode
    typedef struct packed {
        logic load;    // take the incoming entry
        logic shift;   // take the left neighbour's entry
        logic rd_sel;  // drive this entry onto the read bus
    } t_cell_ctrl;

endpackage

// File: sv/sorted_insert_priority_queue.sv
// ----------------------------------------------------------------------------
// sorted_insert_priority_queue: sorted list of key/tag entries
// Output: a word is answered in the output register in the cycle after it is
//   accepted.
// Throughput: one word per cycle, insert or read, while no result is held; set
//   by the compare across the cell row plus the prefix search for the slot.
// Reset: count and order mode cleared, output empty; entry payloads are not
//   reset and are never shown before they are written.
// ----------------------------------------------------------------------------
module sorted_insert_priority_queue
    import sipq_pkg::*;
#(
    parameter int DEPTH = SIPQ_DEPTH
)(
    input  logic       i_clk,
    input  logic       i_rst_n,
    // configuration: order mode
    input  logic       i_cfg_we,
    input  logic       i_cfg_wdata,
    // input channel
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  t_in_word   i_in_data,
    // output channel
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output t_out_word  o_out_data
);

    localparam int CNT_W = $clog2(DEPTH + 1);

    // control state
    logic                     r_desc;
    logic [CNT_W-1:0]         r_count, n_count;
    logic signed [KEY_W-1:0]  r_last_key, n_last_key;
    logic                     r_out_valid;
    t_out_word                r_out, n_out;

    // decode
    logic                     w_accept, w_ins, w_full, w_front, w_back, w_read;
    logic                     w_rd_valid;
    logic [DEPTH-1:0]         w_stop, w_live, w_found;
    t_cell_ctrl               w_ctrl   [DEPTH];
    logic signed [KEY_W-1:0]  w_key    [DEPTH];
    logic        [TAG_W-1:0]  w_tag    [DEPTH];
    logic signed [KEY_W-1:0]  w_rd_key [DEPTH];
    logic        [TAG_W-1:0]  w_rd_tag [DEPTH];
    logic signed [KEY_W-1:0]  w_sel_key;
    logic        [TAG_W-1:0]  w_sel_tag;

    // the output register parts the two sides; input waits only on a held word
    assign o_in_stall = r_out_valid && i_out_stall;
    assign w_accept   = i_in_valid && !o_in_stall;
    assign w_read     = (i_in_data.op == OP_READ);
    assign w_full     = (r_count == CNT_W'(DEPTH));
    assign w_ins      = w_accept && !w_read && !w_full;

    // front: empty queue, or new key at or before the first entry
    assign w_front = (r_count == '0) || w_stop[0];
    // back: new key at or after the last entry in the current order
    assign w_back  = r_desc ? !(i_in_data.key > r_last_key)
                            : !(i_in_data.key < r_last_key);

    genvar g;
    generate
        for (g = 0; g < DEPTH; g++) begin : g_cell
            logic w_is_count;

            assign w_live[g]  = CNT_W'(g) < r_count;
            assign w_is_count = CNT_W'(g) == r_count;

            // any live stopping cell to the left: slot lies before this cell
            if (g == 0) begin : g_first
                assign w_found[g] = 1'b0;
            end else begin : g_rest
                assign w_found[g] = |(w_stop[g-1:0] & w_live[g-1:0]);
            end

            always_comb begin
                w_ctrl[g].load = 1'b0;
                if (w_ins) begin
                    if (w_front) begin
                        w_ctrl[g].load = (g == 0);
                    end else if (w_back) begin
                        w_ctrl[g].load = w_is_count;
                    end else begin
                        w_ctrl[g].load = w_live[g] && w_stop[g] && !w_found[g];
                    end
                end
                // cells after the slot up to the old count move one place right
                w_ctrl[g].shift = w_ins && (g != 0) && (CNT_W'(g) <= r_count)
                                  && (w_front || (!w_back && w_found[g]));
                w_ctrl[g].rd_sel = (i_in_data.position == POS_W'(g));
            end

            if (g == 0) begin : g_edge
                sipq_cell u_cell (
                    .i_clk        (i_clk),
                    .i_key        (i_in_data.key),
                    .i_tag        (i_in_data.tag),
                    .i_left_key   ('0),
                    .i_left_tag   ('0),
                    .i_descending (r_desc),
                    .i_ctrl       (w_ctrl[g]),
                    .o_key        (w_key[g]),
                    .o_tag        (w_tag[g]),
                    .o_stop       (w_stop[g]),
                    .o_rd_key     (w_rd_key[g]),
                    .o_rd_tag     (w_rd_tag[g])
                );
            end else begin : g_inner
                sipq_cell u_cell (
                    .i_clk        (i_clk),
                    .i_key        (i_in_data.key),
                    .i_tag        (i_in_data.tag),
                    .i_left_key   (w_key[g-1]),
                    .i_left_tag   (w_tag[g-1]),
                    .i_descending (r_desc),
                    .i_ctrl       (w_ctrl[g]),
                    .o_key        (w_key[g]),
                    .o_tag        (w_tag[g]),
                    .o_stop       (w_stop[g]),
                    .o_rd_key     (w_rd_key[g]),
                    .o_rd_tag     (w_rd_tag[g])
                );
            end
        end
    endgenerate

    // read bus: at most one cell drives a non-zero word
    always_comb begin
        w_sel_key = '0;
        w_sel_tag = '0;
        for (int i = 0; i < DEPTH; i++) begin
            w_sel_key = w_sel_key | w_rd_key[i];
            w_sel_tag = w_sel_tag | w_rd_tag[i];
        end
    end

    assign w_rd_valid = ENTRY_COUNT_W'(i_in_data.position) < ENTRY_COUNT_W'(r_count);

    always_comb begin
        n_count    = w_ins ? r_count + CNT_W'(1) : r_count;
        // last entry changes only when the new one lands at the tail
        n_last_key = r_last_key;
        if (w_ins && ((r_count == '0) || (!w_front && w_back))) begin
            n_last_key = i_in_data.key;
        end

        n_out             = '0;
        n_out.entry_count = ENTRY_COUNT_W'(n_count);
        if (w_read) begin
            n_out.read_valid = w_rd_valid;
            if (w_rd_valid) begin
                n_out.out_key = w_sel_key;
                n_out.out_tag = w_sel_tag;
            end
        end else begin
            n_out.overflow = w_full;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_desc      <= 1'b0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_desc <= i_cfg_wdata;
            end
            r_count <= n_count;
            if (w_accept) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_last_key <= n_last_key;
        if (w_accept) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

// File: sv/sipq_cell.sv
// ----------------------------------------------------------------------------
// sipq_cell: one slot of the sorted chain
// Holds one key/tag pair, compares the incoming key against it and takes
// either the incoming entry or its left neighbour's entry.
// ----------------------------------------------------------------------------
module sipq_cell
    import sipq_pkg::*;
(
    input  logic                     i_clk,
    input  logic signed [KEY_W-1:0]  i_key,
    input  logic        [TAG_W-1:0]  i_tag,
    input  logic signed [KEY_W-1:0]  i_left_key,
    input  logic        [TAG_W-1:0]  i_left_tag,
    input  logic                     i_descending,
    input  t_cell_ctrl               i_ctrl,
    output logic signed [KEY_W-1:0]  o_key,
    output logic        [TAG_W-1:0]  o_tag,
    output logic                     o_stop,
    output logic signed [KEY_W-1:0]  o_rd_key,
    output logic        [TAG_W-1:0]  o_rd_tag
);

    logic signed [KEY_W-1:0] r_key, n_key;
    logic        [TAG_W-1:0] r_tag, n_tag;
    logic                    w_gt, w_lt;

    assign w_gt = i_key > r_key;
    assign w_lt = i_key < r_key;

    // stop: the new key does not pass this entry in the current order
    assign o_stop = i_descending ? !w_lt : !w_gt;

    always_comb begin
        n_key = r_key;
        n_tag = r_tag;
        if (i_ctrl.load) begin
            n_key = i_key;
            n_tag = i_tag;
        end else if (i_ctrl.shift) begin
            n_key = i_left_key;
            n_tag = i_left_tag;
        end
    end

    always_ff @(posedge i_clk) begin
        r_key <= n_key;
        r_tag <= n_tag;
    end

    assign o_key    = r_key;
    assign o_tag    = r_tag;
    assign o_rd_key = i_ctrl.rd_sel ? r_key : '0;
    assign o_rd_tag = i_ctrl.rd_sel ? r_tag : '0;

endmodule

// File: sv/sipq_checker.sv
// ----------------------------------------------------------------------------
// sipq_checker: port-level checks of the sorted insert priority queue
// Watches both channels and the result words; bound to the top level.
// ----------------------------------------------------------------------------
module sipq_checker
    import sipq_pkg::*;
#(
    parameter int DEPTH = SIPQ_DEPTH
)(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic       i_in_stall,
    input  logic       i_out_valid,
    input  logic       i_out_stall,
    input  t_out_word  i_out_data
);

    // a held result word stays put
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_stall |=> i_out_valid && $stable(i_out_data))
        else $error("held result word changed");

    // every accepted word is answered in the next cycle
    a_answer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !i_in_stall |=> i_out_valid)
        else $error("accepted word not answered");

    // a dropped insert only happens on a full queue
    a_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_data.overflow |->
            !i_out_data.read_valid && (i_out_data.entry_count == ENTRY_COUNT_W'(DEPTH)))
        else $error("overflow on a queue that is not full");

    // no entry is shown without a valid read
    a_no_leak: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_data.read_valid |->
            (i_out_data.out_key == '0) && (i_out_data.out_tag == '0))
        else $error("entry data shown without a valid read");

endmodule

bind sorted_insert_priority_queue sipq_checker #(
    .DEPTH (DEPTH)
) u_sipq_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .i_in_stall  (o_in_stall),
    .i_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .i_out_data  (o_out_data)
);
